// ----- rtl/assert_macros.svh -----
// assertion macros for the checker file of the key sequence matcher
// each macro expects clk and rst (synchronous, active high) in scope

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every rising clock edge outside reset
`define KSM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define KSM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ksm_pkg.sv -----
// ksm_pkg: sizes, codes, command and configuration types, byte helpers
// used by every module of the key sequence matcher; depends on nothing
`default_nettype none

package ksm_pkg;

  localparam int NUM_SEQS    = 6;
  localparam int MAX_SEQ_LEN = 8;
  localparam int BYTE_W      = 8;
  localparam int SEQ_BITS    = 64;
  localparam int IDX_W       = 3;
  localparam int LEN_W       = 3;
  localparam int KLEN_W      = LEN_W + 1;
  localparam int TMO_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int Q_DEPTH     = 2;
  localparam int QPTR_W      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(Q_DEPTH + 1);

  // configuration register indexes beyond the sequence bank
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_COUNT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd7;

  typedef enum logic [0:0] {
    OP_CHAR = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    KIND_REPLAY  = 3'd0,
    KIND_NOMATCH = 3'd1,
    KIND_PARTIAL = 3'd2,
    KIND_FULL    = 3'd3,
    KIND_TIMEOUT = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPLAY,
    ST_TOUT
  } st_t;

  typedef struct packed {
    op_t               op;
    logic              is_zero;
    logic [BYTE_W-1:0] ch;
  } cmd_t;

  typedef logic [NUM_SEQS-1:0][SEQ_BITS-1:0] seq_bank_t;

  typedef struct packed {
    seq_bank_t        seqs;
    logic [IDX_W-1:0] count;
    logic [TMO_W-1:0] timeout;
  } cfg_t;

  // byte k of a sequence word, zero past the maximum length
  function automatic logic [BYTE_W-1:0] seq_byte(input logic [SEQ_BITS-1:0] s,
                                                 input logic [KLEN_W-1:0] k);
    logic [BYTE_W-1:0] r;
    r = '0;
    for (int i = 0; i < MAX_SEQ_LEN; i++) begin
      if (k == KLEN_W'(i)) r = s[BYTE_W*i +: BYTE_W];
    end
    return r;
  endfunction

  // first n bytes of both words agree
  function automatic logic same_prefix(input logic [SEQ_BITS-1:0] a,
                                       input logic [SEQ_BITS-1:0] b,
                                       input logic [KLEN_W-1:0] n);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < MAX_SEQ_LEN; i++) begin
      if ((KLEN_W'(i) < n) && (a[BYTE_W*i +: BYTE_W] != b[BYTE_W*i +: BYTE_W])) ok = 1'b0;
    end
    return ok;
  endfunction

  // byte n exists (no zero byte up to it) and equals c
  function automatic logic seq_hit(input logic [SEQ_BITS-1:0] s,
                                   input logic [KLEN_W-1:0] n,
                                   input logic [BYTE_W-1:0] c);
    logic ok;
    ok = (n < KLEN_W'(MAX_SEQ_LEN));
    for (int i = 0; i < MAX_SEQ_LEN; i++) begin
      if ((KLEN_W'(i) <= n) && (s[BYTE_W*i +: BYTE_W] == '0)) ok = 1'b0;
    end
    return ok && (seq_byte(s, n) == c);
  endfunction

  // matching byte n completes the sequence
  function automatic logic seq_full(input logic [SEQ_BITS-1:0] s,
                                    input logic [KLEN_W-1:0] n);
    logic [KLEN_W-1:0] nx;
    nx = n + 1'b1;
    return (nx >= KLEN_W'(MAX_SEQ_LEN)) || (seq_byte(s, nx) == '0);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ksm_front.sv -----
// ksm_front: input register stage that takes items and classifies them
// into commands for the queue; uses ksm_pkg
`default_nettype none

module ksm_front import ksm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              opcode,
  input  wire logic [BYTE_W-1:0] char_in,
  output logic                   cmd_valid,
  input  wire logic              cmd_ready,
  output cmd_t                   cmd
);

  logic held;
  cmd_t cmd_reg;

  assign in_ready  = !held || cmd_ready;
  assign cmd_valid = held;
  assign cmd       = cmd_reg;

  // occupancy of the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (cmd_ready) begin
      held <= 1'b0;
    end
  end

  // classify on transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_reg.op      <= opcode ? OP_TICK : OP_CHAR;
      cmd_reg.is_zero <= (char_in == '0);
      cmd_reg.ch      <= char_in;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ksm_queue.sv -----
// ksm_queue: short command queue between front and back
// depth set by Q_DEPTH in ksm_pkg
`default_nettype none

module ksm_queue import ksm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  cmd_t      push_cmd,
  output logic      pop_valid,
  input  wire logic pop,
  output cmd_t      pop_cmd
);

  cmd_t              entries [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != QCNT_W'(Q_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(Q_DEPTH - 1)) ? '0 : QPTR_W'(p + 1'b1);
  endfunction

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop)  rd_ptr <= ptr_inc(rd_ptr);
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_cmd;
  end

endmodule

`default_nettype wire

// ----- rtl/ksm_back.sv -----
// ksm_back: matching sequencer, match state and result register; uses ksm_pkg
// scans one sequence per cycle; replays held bytes one per cycle unless stalled
`default_nettype none

module ksm_back import ksm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  cfg_t                   cfg,
  input  wire logic              cmd_valid,
  output logic                   cmd_pop,
  input  cmd_t                   cmd,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output kind_t                  kind,
  output logic [BYTE_W-1:0]      char_out,
  output logic [IDX_W-1:0]       seq_index,
  output logic                   last
);

  st_t                 state;
  st_t                 state_next;
  logic [IDX_W-1:0]    candidate;
  logic [LEN_W-1:0]    matched;
  logic [TMO_W-1:0]    idle_ticks;
  logic [IDX_W-1:0]    cand;
  logic [LEN_W-1:0]    len;
  logic [LEN_W-1:0]    k;
  logic [SEQ_BITS-1:0] held_seq;
  logic [BYTE_W-1:0]   ch;
  logic                czero;
  logic                tout_mode;

  logic [IDX_W-1:0]    count_eff;
  logic [IDX_W-1:0]    sel;
  logic [SEQ_BITS-1:0] rd_seq;
  logic [KLEN_W-1:0]   len_k;
  logic                in_range;
  logic                hit;
  logic                full;
  logic                k_last;
  logic                can_emit;
  logic [TMO_W-1:0]    idle_inc;
  logic                tmo_fire;

  logic                emit;
  kind_t               res_kind;
  logic [BYTE_W-1:0]   res_char;
  logic [IDX_W-1:0]    res_idx;
  logic                res_last;

  // sequence read port and match evaluation
  always_comb begin
    count_eff = (cfg.count > IDX_W'(NUM_SEQS)) ? IDX_W'(NUM_SEQS) : cfg.count;
    sel       = (state == ST_IDLE) ? candidate : cand;
    rd_seq    = (sel < IDX_W'(NUM_SEQS)) ? cfg.seqs[sel] : '0;
    len_k     = {1'b0, len};
    in_range  = (cand < count_eff);
    hit       = in_range && !czero && seq_hit(rd_seq, len_k, ch)
                && same_prefix(held_seq, rd_seq, len_k);
    full      = seq_full(rd_seq, len_k);
    k_last    = (k == LEN_W'(len - 1'b1));
    can_emit  = !out_valid || out_ready;
    idle_inc  = (idle_ticks == '1) ? idle_ticks : idle_ticks + 1'b1;
    tmo_fire  = (matched != '0) && (cfg.timeout != '0) && (idle_inc >= cfg.timeout);
    cmd_pop   = (state == ST_IDLE) && cmd_valid;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == OP_CHAR) state_next = ST_SCAN;
          else if (tmo_fire)     state_next = ST_REPLAY;
        end
      end
      ST_SCAN: begin
        if (in_range) begin
          if (hit && can_emit) state_next = ST_IDLE;
        end else if (len == '0) begin
          if (can_emit) state_next = ST_IDLE;
        end else begin
          state_next = ST_REPLAY;
        end
      end
      ST_REPLAY: begin
        if (can_emit && k_last) state_next = tout_mode ? ST_TOUT : ST_SCAN;
      end
      ST_TOUT: begin
        if (can_emit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // result generation
  always_comb begin
    emit     = 1'b0;
    res_kind = KIND_NOMATCH;
    res_char = '0;
    res_idx  = '0;
    res_last = 1'b1;
    unique case (state)
      ST_SCAN: begin
        if (in_range && hit) begin
          emit     = can_emit;
          res_kind = full ? KIND_FULL : KIND_PARTIAL;
          res_idx  = full ? cand : '0;
        end else if (!in_range && (len == '0)) begin
          emit     = can_emit;
          res_kind = KIND_NOMATCH;
          res_char = ch;
        end
      end
      ST_REPLAY: begin
        emit     = can_emit;
        res_kind = KIND_REPLAY;
        res_char = seq_byte(held_seq, {1'b0, k});
        res_last = 1'b0;
      end
      ST_TOUT: begin
        emit     = can_emit;
        res_kind = KIND_TIMEOUT;
      end
      default: emit = 1'b0;
    endcase
  end

  // control state and match state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      candidate  <= '0;
      matched    <= '0;
      idle_ticks <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (emit)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid && (cmd.op == OP_TICK)) idle_ticks <= idle_inc;
        end
        ST_SCAN: begin
          if (in_range && hit && can_emit) begin
            if (full) begin
              candidate  <= '0;
              matched    <= '0;
            end else begin
              candidate  <= cand;
              matched    <= LEN_W'(len + 1'b1);
            end
            idle_ticks <= '0;
          end else if (!in_range && (len == '0) && can_emit) begin
            candidate  <= '0;
            matched    <= '0;
            idle_ticks <= '0;
          end
        end
        ST_REPLAY: begin
          if (can_emit && k_last && !tout_mode) begin
            candidate  <= '0;
            matched    <= '0;
            idle_ticks <= '0;
          end
        end
        ST_TOUT: begin
          if (can_emit) begin
            candidate  <= '0;
            matched    <= '0;
            idle_ticks <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers of the current command
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          held_seq  <= rd_seq;
          cand      <= candidate;
          len       <= matched;
          ch        <= cmd.ch;
          czero     <= cmd.is_zero;
          tout_mode <= (cmd.op == OP_TICK);
          k         <= '0;
        end
      end
      ST_SCAN: begin
        if (in_range && !hit) cand <= IDX_W'(cand + 1'b1);
        k <= '0;
      end
      ST_REPLAY: begin
        if (can_emit) begin
          k <= LEN_W'(k + 1'b1);
          if (k_last && !tout_mode) begin
            cand <= '0;
            len  <= '0;
          end
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      kind      <= res_kind;
      char_out  <= res_char;
      seq_index <= res_idx;
      last      <= res_last;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/key_sequence_matcher_core.sv -----
// key_sequence_matcher_core: top level with configuration registers,
// built from ksm_front, ksm_queue and ksm_back; uses ksm_pkg
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid in_ready opcode char_in          | input
//   out     | out_valid out_ready kind char_out         | output
//           | seq_index last                            |
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data    | input
//
// a character is dispatched from the queue, then the scan probes the sequences in
// turn (up to 6) with a closing step when none hits, replays the held bytes
// (up to 7) and runs a second scan after a replay
// a tick is dispatched and, when it times out, replays the held bytes and then gives a timeout result
// every result waits in the output register; a stall there holds the sequencer,
// while the front stage and the two-entry queue keep taking items
// reset clears match state, configuration and all valid flags at once
`default_nettype none

module key_sequence_matcher_core import ksm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 opcode,
  input  wire logic [BYTE_W-1:0]    char_in,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [2:0]                kind,
  output logic [BYTE_W-1:0]         char_out,
  output logic [IDX_W-1:0]          seq_index,
  output logic                      last,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SEQ_BITS-1:0]  cfg_data
);

  cfg_t  cfg;
  logic  f_valid;
  logic  f_ready;
  cmd_t  f_cmd;
  logic  q_valid;
  logic  q_pop;
  cmd_t  q_cmd;
  kind_t b_kind;

  assign cfg_ready = 1'b1;
  assign kind      = b_kind;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index < CFG_IDX_W'(NUM_SEQS)) begin
        cfg.seqs[cfg_index] <= cfg_data;
      end else if (cfg_index == CFG_SEQ_COUNT) begin
        cfg.count <= cfg_data[IDX_W-1:0];
      end else if (cfg_index == CFG_TIMEOUT) begin
        cfg.timeout <= cfg_data[TMO_W-1:0];
      end
    end
  end

  ksm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .char_in   (char_in),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  ksm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  ksm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (q_valid),
    .cmd_pop   (q_pop),
    .cmd       (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (b_kind),
    .char_out  (char_out),
    .seq_index (seq_index),
    .last      (last)
  );

endmodule

`default_nettype wire

// ----- rtl/ksm_checker.sv -----
// ksm_checker: port-level assertions on the result channel, bound to the top
// uses ksm_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module ksm_checker import ksm_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [2:0]        kind,
  input wire logic [BYTE_W-1:0] char_out,
  input wire logic [IDX_W-1:0]  seq_index,
  input wire logic              last
);

  // a stalled result holds
  `KSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(char_out) && $stable(seq_index) && $stable(last), "result changed while stalled")

  // only a full match carries an index
  `KSM_ASSERT_IMPL(a_idx_full, out_valid && (kind != KIND_FULL), seq_index == '0, "index on a result other than full match")

  // match and timeout results carry no character
  `KSM_ASSERT_IMPL(a_char_zero, out_valid && ((kind == KIND_PARTIAL) || (kind == KIND_FULL) || (kind == KIND_TIMEOUT)), char_out == '0, "character on a match or timeout result")

  // replayed bytes are never last, everything else is
  `KSM_ASSERT_IMPL(a_last_kind, out_valid, last == (kind != KIND_REPLAY), "last flag does not fit result kind")

endmodule

bind key_sequence_matcher_core ksm_checker u_ksm_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .kind      (kind),
  .char_out  (char_out),
  .seq_index (seq_index),
  .last      (last)
);

`default_nettype wire

// ----- dv/tb_key_sequence_matcher_core.sv -----
// testbench for key_sequence_matcher_core: random and directed key streams,
// a local match predictor and an in-order check of every result transfer
// depends on ksm_pkg and the core rtl only
`timescale 1ns / 100ps

module tb_key_sequence_matcher_core;
  import ksm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_0 = 3'd0;
  localparam int HOLD_AT      = 110;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int END_LIMIT    = 100000;
  localparam int MAX_REPORTS  = 10;
  localparam int RUN_LIMIT_NS = 20000000;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] ch;
  } key_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
    logic              last;
  } key_event_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 opcode = 1'b0;
  logic [BYTE_W-1:0]    char_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [2:0]           kind;
  logic [BYTE_W-1:0]    char_out;
  logic [IDX_W-1:0]     seq_index;
  logic                 last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SEQ_BITS-1:0]  cfg_data = '0;

  // predictor copy of configuration and match state
  logic [SEQ_BITS-1:0]  mt_seq_words [NUM_SEQS];
  logic [IDX_W-1:0]     mt_count = '0;
  logic [TMO_W-1:0]     mt_timeout = '0;
  logic [IDX_W-1:0]     held_seq = '0;
  logic [LEN_W-1:0]     held_len = '0;
  logic [TMO_W-1:0]     tick_age = '0;

  key_item_t  char_feed[$];
  key_event_t awaited_events[$];
  key_item_t  item_now;
  key_event_t want_event;
  int         item_event_cnt;
  int         accepted_items = 0;
  int         err_count = 0;
  int         tx_idle_pct = 24;
  int         rx_idle_pct = 24;
  logic       rx_hold = 1'b0;
  logic [BYTE_W-1:0] alpha_base = 8'h41;

  key_sequence_matcher_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .char_in   (char_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .char_out  (char_out),
    .seq_index (seq_index),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    for (int s = 0; s < NUM_SEQS; s++) mt_seq_words[s] = '0;
  end

  // byte k of sequence s, zero outside the bank
  function automatic logic [BYTE_W-1:0] pat_byte(input int s, input int k);
    if (s >= NUM_SEQS || k >= MAX_SEQ_LEN) return '0;
    return mt_seq_words[s][BYTE_W*k +: BYTE_W];
  endfunction

  function automatic int pat_len(input int s);
    for (int k = 0; k < MAX_SEQ_LEN; k++) begin
      if (pat_byte(s, k) == '0) return k;
    end
    return MAX_SEQ_LEN;
  endfunction

  function automatic void drop_held();
    held_seq = '0;
    held_len = '0;
    tick_age = '0;
  endfunction

  function automatic void emit_event(input kind_t k, input logic [BYTE_W-1:0] c,
                                     input logic [IDX_W-1:0] i);
    key_event_t ev;
    ev.kind = k;
    ev.ch   = c;
    ev.idx  = i;
    ev.last = 1'b0;
    awaited_events.push_back(ev);
    item_event_cnt++;
  endfunction

  function automatic void replay_held(input int s, input int n);
    for (int k = 0; k < n; k++) emit_event(KIND_REPLAY, pat_byte(s, k), '0);
  endfunction

  // expected result transfers for one accepted item
  function automatic void predict_key_item(input op_t op, input logic [BYTE_W-1:0] c);
    int cnt, src, cand, len, nxt, k;
    bit done, same;
    key_event_t ev;
    item_event_cnt = 0;
    if (op == OP_CHAR) begin
      cnt  = (mt_count > NUM_SEQS) ? NUM_SEQS : int'(mt_count);
      src  = held_seq;
      cand = held_seq;
      len  = held_len;
      done = 1'b0;
      while (!done) begin
        if (cand < cnt && c != '0 && len < pat_len(cand) && pat_byte(cand, len) == c) begin
          len++;
          if (len >= pat_len(cand)) begin
            emit_event(KIND_FULL, '0, IDX_W'(cand));
            drop_held();
          end else begin
            held_seq = IDX_W'(cand);
            held_len = LEN_W'(len);
            tick_age = '0;
            emit_event(KIND_PARTIAL, '0, '0);
          end
          done = 1'b1;
        end else begin
          // next sequence sharing the matched prefix of the held one
          nxt = cand + 1;
          while (nxt < cnt && len > 0) begin
            same = 1'b1;
            for (k = 0; k < len; k++) begin
              if (pat_byte(src, k) != pat_byte(nxt, k)) same = 1'b0;
            end
            if (same) break;
            nxt++;
          end
          if (nxt < cnt) begin
            cand = nxt;
          end else if (len == 0) begin
            emit_event(KIND_NOMATCH, c, '0);
            drop_held();
            done = 1'b1;
          end else begin
            // give back the held characters and retry from the first sequence
            replay_held(src, len);
            drop_held();
            src  = 0;
            cand = 0;
            len  = 0;
          end
        end
      end
    end else begin
      if (tick_age != '1) tick_age++;
      if (held_len != '0 && mt_timeout != '0 && tick_age >= mt_timeout) begin
        replay_held(held_seq, held_len);
        emit_event(KIND_TIMEOUT, '0, '0);
        drop_held();
      end
    end
    if (item_event_cnt != 0) begin
      ev = awaited_events.pop_back();
      ev.last = 1'b1;
      awaited_events.push_back(ev);
    end
  endfunction

  function automatic void note_failure(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // input driver: one transfer per handshake, fed from char_feed
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_key_item(op_t'(opcode), char_in);
        accepted_items <= accepted_items + 1;
      end
      if (!in_valid || in_ready) begin
        if (char_feed.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          item_now = char_feed.pop_front();
          in_valid <= 1'b1;
          opcode   <= item_now.op;
          char_in  <= item_now.ch;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver backpressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_events.size() == 0) begin
          note_failure($sformatf("unexpected result: kind=%0d char=%02h idx=%0d last=%0b",
                                 kind, char_out, seq_index, last));
        end else begin
          want_event = awaited_events.pop_front();
          if (kind !== want_event.kind || char_out !== want_event.ch ||
              seq_index !== want_event.idx || last !== want_event.last)
            note_failure($sformatf({"result differs: expected kind=%0d char=%02h idx=%0d ",
                                    "last=%0b, got kind=%0d char=%02h idx=%0d last=%0b"},
                                   want_event.kind, want_event.ch, want_event.idx,
                                   want_event.last, kind, char_out, seq_index, last));
        end
      end
      out_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    while (accepted_items < HOLD_AT) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

  function automatic void feed(input op_t op, input logic [BYTE_W-1:0] c);
    key_item_t it;
    it.op = op;
    it.ch = c;
    char_feed.push_back(it);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SEQ_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SEQ_COUNT: mt_count = val[IDX_W-1:0];
      CFG_TIMEOUT:   mt_timeout = val[TMO_W-1:0];
      default:       mt_seq_words[idx] = val;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_results();
    while (char_feed.size() != 0 || in_valid || awaited_events.size() != 0) @(posedge clk);
  endtask

  // quiet block before a register write, covering items with no result
  task automatic settle();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random sequences over a small alphabet, often sharing prefixes
  task automatic load_setup(input logic [IDX_W-1:0] count_val, input logic [TMO_W-1:0] tmo_val);
    logic [SEQ_BITS-1:0] w, prev;
    int s, k, wl, shared;
    alpha_base = 8'($urandom_range(1, 250));
    prev = '0;
    for (s = 0; s < NUM_SEQS; s++) begin
      w = '0;
      wl = ($urandom_range(0, 7) == 0) ? MAX_SEQ_LEN : $urandom_range(1, 4);
      shared = $urandom_range(0, 3);
      for (k = 0; k < wl; k++) begin
        if (k < shared && prev[BYTE_W*k +: BYTE_W] != '0)
          w[BYTE_W*k +: BYTE_W] = prev[BYTE_W*k +: BYTE_W];
        else
          w[BYTE_W*k +: BYTE_W] = alpha_base + 8'($urandom_range(0, 3));
      end
      // junk after the terminating zero byte
      if (wl < MAX_SEQ_LEN - 1 && $urandom_range(0, 4) == 0) begin
        for (k = wl + 1; k < MAX_SEQ_LEN; k++) w[BYTE_W*k +: BYTE_W] = 8'($urandom);
      end
      // dead sequence with a zero first byte
      if ($urandom_range(0, 11) == 0) w[BYTE_W-1:0] = '0;
      write_reg(CFG_SEQ_0 + CFG_IDX_W'(s), w);
      prev = w;
    end
    write_reg(CFG_SEQ_COUNT, {32'($urandom), 29'($urandom), count_val});
    write_reg(CFG_TIMEOUT, {32'($urandom), tmo_val});
  endtask

  // mostly whole or partial key sequences, some broken, plus ticks and noise
  task automatic queue_traffic(input int n_items);
    int added, cnt, s, plen, k, pick, bad_at;
    logic [BYTE_W-1:0] c;
    added = 0;
    cnt = (mt_count > NUM_SEQS) ? NUM_SEQS : int'(mt_count);
    while (added < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 6 && cnt > 0) begin
        s = $urandom_range(0, cnt - 1);
        plen = pat_len(s);
        if (plen == 0) plen = 1;
        if (pick >= 4) plen = $urandom_range(1, plen);
        bad_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, plen - 1) : -1;
        for (k = 0; k < plen; k++) begin
          c = pat_byte(s, k);
          if (k == bad_at || c == '0) c = alpha_base + 8'($urandom_range(0, 4));
          feed(OP_CHAR, c);
        end
        added += plen;
      end else if (pick < 8) begin
        feed(OP_TICK, 8'($urandom));
        added++;
      end else begin
        case ($urandom_range(0, 2))
          0:       c = '0;
          1:       c = alpha_base + 8'($urandom_range(0, 4));
          default: c = 8'($urandom);
        endcase
        feed(OP_CHAR, c);
        added++;
      end
    end
  endtask

  // main sequence of phases
  initial begin
    int guard;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: escape-style keys, a full-length all-ones key, a dead key
    write_reg(CFG_SEQ_0 + 3'd0, 64'h0000_0000_0041_5B1B);
    write_reg(CFG_SEQ_0 + 3'd1, 64'h0000_0000_0042_5B1B);
    write_reg(CFG_SEQ_0 + 3'd2, 64'h0000_0000_0050_4F1B);
    write_reg(CFG_SEQ_0 + 3'd3, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_SEQ_0 + 3'd4, 64'h0000_0000_0000_4100);
    write_reg(CFG_SEQ_0 + 3'd5, 64'h0102_0304_0506_0708);
    write_reg(CFG_SEQ_COUNT, 64'd7);
    write_reg(CFG_TIMEOUT, 64'd3);
    feed(OP_CHAR, 8'h1B); feed(OP_CHAR, 8'h5B); feed(OP_CHAR, 8'h41);
    feed(OP_CHAR, 8'h1B); feed(OP_CHAR, 8'h5B); feed(OP_CHAR, 8'h42);
    feed(OP_CHAR, 8'h1B); feed(OP_CHAR, 8'h4F); feed(OP_CHAR, 8'h50);
    feed(OP_CHAR, 8'h1B); feed(OP_CHAR, 8'h5B); feed(OP_CHAR, 8'h58);
    feed(OP_CHAR, 8'h00);
    feed(OP_CHAR, 8'h41);
    repeat (MAX_SEQ_LEN) feed(OP_CHAR, 8'hFF);
    feed(OP_CHAR, 8'h1B);
    repeat (3) feed(OP_TICK, 8'($urandom));
    feed(OP_CHAR, 8'h1B);

    // random phases; a prefix may still be held across each register update
    settle();
    load_setup(3'd6, 32'd2);
    queue_traffic(35);

    settle();
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    load_setup(3'd3, 32'd0);
    queue_traffic(35);

    settle();
    tx_idle_pct <= 24;
    rx_idle_pct <= 24;
    load_setup(3'd7, 32'hFFFF_FFFF);
    queue_traffic(40);

    settle();
    load_setup(3'd0, 32'd1);
    queue_traffic(15);

    settle();
    load_setup(3'd6, 32'd1);
    queue_traffic(18);
    wait_results();
    queue_traffic(17);

    settle();
    load_setup(3'd5, 32'd4);
    queue_traffic(35);

    settle();
    load_setup(3'd2, 32'd3);
    queue_traffic(30);

    settle();
    load_setup(3'd6, 32'd0);
    queue_traffic(35);

    // drain everything still owed
    guard = 0;
    while ((char_feed.size() != 0 || in_valid || awaited_events.size() != 0) &&
           guard < END_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_events.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", awaited_events.size()));
    if (err_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
